[rtl/core/isi_pkg.sv]
// ----------------------------------------------------------------------------
// isi_pkg: shared types and constants of the index set intersection unit
// request codes, queue entry and result layouts, sizing constants
// ----------------------------------------------------------------------------
`default_nettype none

package isi_pkg;

   // sizing
   localparam int CAPACITY   = 32;
   localparam int INDEX_BITS = 32;
   localparam int VALUE_W    = 32;
   localparam int KEY_W      = (INDEX_BITS < VALUE_W) ? INDEX_BITS : VALUE_W;
   localparam int REF_CNT_W  = $clog2(CAPACITY + 1);
   localparam int REF_IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int HITS_W     = 6;
   localparam logic [HITS_W-1:0] HITS_MAX = '1;

   // request queue between front and back
   localparam int QDEPTH  = 4;
   localparam int QPTR_W  = $clog2(QDEPTH);
   localparam int QCNT_W  = $clog2(QDEPTH + 1);

   // result buffer
   localparam int RDEPTH  = 2;
   localparam int RPTR_W  = $clog2(RDEPTH);
   localparam int RCNT_W  = $clog2(RDEPTH + 1);

   // request command codes
   localparam logic [1:0] CMD_CLEAR  = 2'd0;
   localparam logic [1:0] CMD_APPEND = 2'd1;
   localparam logic [1:0] CMD_PROBE  = 2'd2;

   typedef enum logic [1:0] {
      OP_CLEAR,
      OP_APPEND,
      OP_PROBE
   } op_type;

   typedef struct packed {
      op_type             op;
      logic [VALUE_W-1:0] value;
      logic               last;
   } req_entry_type;

   // head of the request queue as seen by the back end
   typedef struct packed {
      logic          valid;
      req_entry_type entry;
   } queue_head_type;

   typedef struct packed {
      logic [VALUE_W-1:0] probe_index;
      logic               is_member;
      logic               all_members;
      logic [HITS_W-1:0]  common_count;
      logic               overflowed;
      logic               final_res;
   } rsp_type;

endpackage

`default_nettype wire

[rtl/core/isi_front.sv]
// ----------------------------------------------------------------------------
// isi_front: request decode and request queue
// classifies incoming requests, drops unused codes, queues the rest
// ----------------------------------------------------------------------------
`default_nettype none

module isi_front (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_push,
   output logic                         req_full,
   input  wire logic [1:0]              req_cmd,
   input  wire logic [isi_pkg::VALUE_W-1:0] req_value,
   input  wire logic                    req_last,
   output isi_pkg::queue_head_type      head,
   input  wire logic                    head_pop
);
   import isi_pkg::*;

   req_entry_type      mem_ff [QDEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  cnt_ff, cnt_in;

   req_entry_type      dec_entry;
   logic               dec_keep;
   logic               accept;
   logic               wr_en;
   logic               rd_en;

   // decode
   always_comb begin
      dec_entry.value = req_value;
      dec_entry.last  = req_last;
      dec_entry.op    = OP_CLEAR;
      dec_keep        = 1'b1;
      unique case (req_cmd)
         CMD_CLEAR:  dec_entry.op = OP_CLEAR;
         CMD_APPEND: dec_entry.op = OP_APPEND;
         CMD_PROBE:  dec_entry.op = OP_PROBE;
         default:    dec_keep     = 1'b0;
      endcase
   end

   assign req_full = (cnt_ff == QCNT_W'(QDEPTH));
   assign accept   = req_push && !req_full;
   assign wr_en    = accept && dec_keep;
   assign rd_en    = head_pop && head.valid;

   assign head.valid = (cnt_ff != '0);
   assign head.entry = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (wr_en) begin
         wr_ptr_in = wr_ptr_ff + QPTR_W'(1);
      end
      if (rd_en) begin
         rd_ptr_in = rd_ptr_ff + QPTR_W'(1);
      end
      case ({wr_en, rd_en})
         2'b10:   cnt_in = cnt_ff + QCNT_W'(1);
         2'b01:   cnt_in = cnt_ff - QCNT_W'(1);
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_ptr_ff] <= dec_entry;
      end
   end

endmodule

`default_nettype wire

[rtl/core/isi_back.sv]
// ----------------------------------------------------------------------------
// isi_back: reference set, running probe state and result buffer
// carries out one queued request per cycle while the result buffer has room
// ----------------------------------------------------------------------------
`default_nettype none

module isi_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  isi_pkg::queue_head_type  head,
   output logic                     head_pop,
   output logic                     rsp_empty,
   input  wire logic                rsp_pop,
   output isi_pkg::rsp_type         rsp
);
   import isi_pkg::*;

   logic [KEY_W-1:0]     entries_ff [CAPACITY];
   logic [REF_CNT_W-1:0] ref_count_ff, ref_count_in;
   logic                 dropped_ff, dropped_in;
   logic                 subset_ff, subset_in;
   logic [HITS_W-1:0]    hits_ff, hits_in;

   rsp_type              res_mem_ff [RDEPTH];
   logic [RPTR_W-1:0]    res_wr_ff, res_rd_ff;
   logic [RCNT_W-1:0]    res_cnt_ff, res_cnt_in;

   logic [KEY_W-1:0]     key;
   logic [CAPACITY-1:0]  hit_vec;
   logic                 member;
   logic                 fire;
   logic                 app_en;
   logic                 res_push;
   logic                 res_take;
   rsp_type              res_new;
   logic                 subset_now;
   logic [HITS_W-1:0]    hits_now;

   assign key  = head.entry.value[KEY_W-1:0];
   assign fire = head.valid && (res_cnt_ff != RCNT_W'(RDEPTH));
   assign head_pop = fire;

   // compare against every live entry
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         hit_vec[i] = (REF_CNT_W'(i) < ref_count_ff) && (entries_ff[i] == key);
      end
   end
   assign member = |hit_vec;

   assign subset_now = subset_ff && member;
   assign hits_now   = (member && (hits_ff != HITS_MAX)) ? hits_ff + HITS_W'(1) : hits_ff;

   assign app_en   = fire && (head.entry.op == OP_APPEND) &&
                     (ref_count_ff < REF_CNT_W'(CAPACITY));
   assign res_push = fire && (head.entry.op == OP_PROBE);
   assign res_take = rsp_pop && !rsp_empty;

   always_comb begin
      res_new.probe_index  = head.entry.value;
      res_new.is_member    = member;
      res_new.all_members  = subset_now;
      res_new.common_count = hits_now;
      res_new.overflowed   = dropped_ff;
      res_new.final_res    = head.entry.last;
   end

   always_comb begin
      ref_count_in = ref_count_ff;
      dropped_in   = dropped_ff;
      subset_in    = subset_ff;
      hits_in      = hits_ff;
      if (fire) begin
         unique case (head.entry.op)
            OP_CLEAR: begin
               ref_count_in = '0;
               dropped_in   = 1'b0;
               subset_in    = 1'b1;
               hits_in      = '0;
            end
            OP_APPEND: begin
               if (app_en) begin
                  ref_count_in = ref_count_ff + REF_CNT_W'(1);
               end else begin
                  dropped_in = 1'b1;
               end
            end
            OP_PROBE: begin
               if (head.entry.last) begin
                  subset_in = 1'b1;
                  hits_in   = '0;
               end else begin
                  subset_in = subset_now;
                  hits_in   = hits_now;
               end
            end
            default: begin
               ref_count_in = ref_count_ff;
            end
         endcase
      end
   end

   always_comb begin
      case ({res_push, res_take})
         2'b10:   res_cnt_in = res_cnt_ff + RCNT_W'(1);
         2'b01:   res_cnt_in = res_cnt_ff - RCNT_W'(1);
         default: res_cnt_in = res_cnt_ff;
      endcase
   end

   assign rsp_empty = (res_cnt_ff == '0);
   assign rsp       = res_mem_ff[res_rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_count_ff <= '0;
         dropped_ff   <= 1'b0;
         subset_ff    <= 1'b1;
         hits_ff      <= '0;
         res_wr_ff    <= '0;
         res_rd_ff    <= '0;
         res_cnt_ff   <= '0;
      end else begin
         ref_count_ff <= ref_count_in;
         dropped_ff   <= dropped_in;
         subset_ff    <= subset_in;
         hits_ff      <= hits_in;
         res_cnt_ff   <= res_cnt_in;
         if (res_push) begin
            res_wr_ff <= res_wr_ff + RPTR_W'(1);
         end
         if (res_take) begin
            res_rd_ff <= res_rd_ff + RPTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (app_en) begin
         entries_ff[ref_count_ff[REF_IDX_W-1:0]] <= key;
      end
      if (res_push) begin
         res_mem_ff[res_wr_ff] <= res_new;
      end
   end

endmodule

`default_nettype wire

[rtl/core/index_set_intersection_unit.sv]
// ----------------------------------------------------------------------------
// index_set_intersection_unit: set membership and intersection engine
// holds a reference index set and answers membership probes against it
// ----------------------------------------------------------------------------
// usage
//   requests enter as a queue: drive req_cmd, req_value and req_last with
//   req_push high; the request is taken on a rising edge where req_full is
//   low. cmd clear empties the reference set, append adds req_value while
//   room remains, probe looks req_value up. the unused code is taken and
//   discarded. only probes produce a response; it waits on the rsp_ ports
//   while rsp_empty is low and leaves on an edge with rsp_pop high
//   a probe is held in the request queue, then in the response buffer
//   throughput: one request per cycle while the response buffer has room,
//   set by the combinational compare of the probe key against all stored
//   entries in the back end; a four-entry request queue decouples decode from
//   execution; a two-entry response buffer lets requests keep flowing while
//   the receiver stalls; when both fill, req_full rises until rsp_pop drains
//   synchronous reset empties both queues and the reference set, clears the
//   overflow flag and restarts the running subset flag and hit count
// ----------------------------------------------------------------------------
`default_nettype none

module index_set_intersection_unit (
   input  wire logic                        clock,
   input  wire logic                        reset,
   // request side
   input  wire logic                        req_push,
   output logic                             req_full,
   input  wire logic [1:0]                  req_cmd,
   input  wire logic [isi_pkg::VALUE_W-1:0] req_value,
   input  wire logic                        req_last,
   // response side
   output logic                             rsp_empty,
   input  wire logic                        rsp_pop,
   output logic [isi_pkg::VALUE_W-1:0]      rsp_probe_index,
   output logic                             rsp_is_member,
   output logic                             rsp_all_members,
   output logic [isi_pkg::HITS_W-1:0]       rsp_common_count,
   output logic                             rsp_overflowed,
   output logic                             rsp_final_res
);
   import isi_pkg::*;

   queue_head_type head;
   logic           head_pop;
   rsp_type        rsp;

   // front end: decode and request queue
   isi_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_cmd   (req_cmd),
      .req_value (req_value),
      .req_last  (req_last),
      .head      (head),
      .head_pop  (head_pop)
   );

   // back end: reference set, running state, response buffer
   isi_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .head_pop  (head_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp       (rsp)
   );

   // response fields out to their own ports
   assign rsp_probe_index  = rsp.probe_index;
   assign rsp_is_member    = rsp.is_member;
   assign rsp_all_members  = rsp.all_members;
   assign rsp_common_count = rsp.common_count;
   assign rsp_overflowed   = rsp.overflowed;
   assign rsp_final_res    = rsp.final_res;

endmodule

`default_nettype wire

[rtl/core/isi_checker.sv]
// ----------------------------------------------------------------------------
// isi_checker: port-level checks of the index set intersection unit
// reset behaviour, response consistency and response hold under stall
// ----------------------------------------------------------------------------
`default_nettype none

module isi_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        req_full,
   input wire logic                        rsp_empty,
   input wire logic                        rsp_pop,
   input wire logic [isi_pkg::VALUE_W-1:0] rsp_probe_index,
   input wire logic                        rsp_is_member,
   input wire logic                        rsp_all_members,
   input wire logic [isi_pkg::HITS_W-1:0]  rsp_common_count
);
   import isi_pkg::*;

   // reset leaves both queues empty
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full))
      else $error("queues not empty after reset");

   // a subset answer needs this probe to be a member
   a_subset_member: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_all_members) |-> rsp_is_member)
      else $error("all_members without is_member");

   // a member answer is counted
   a_member_count: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_is_member) |-> (rsp_common_count != '0))
      else $error("member response with zero count");

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_probe_index)))
      else $error("response changed while stalled");

endmodule

bind index_set_intersection_unit isi_checker u_checker (
   .clock            (clock),
   .reset            (reset),
   .req_full         (req_full),
   .rsp_empty        (rsp_empty),
   .rsp_pop          (rsp_pop),
   .rsp_probe_index  (rsp_probe_index),
   .rsp_is_member    (rsp_is_member),
   .rsp_all_members  (rsp_all_members),
   .rsp_common_count (rsp_common_count)
);

`default_nettype wire

[tb/sv/index_set_intersection_unit_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// index_set_intersection_unit_tb: self-checking bench for the set engine
// a short table of directed requests (empty set, extreme indices, duplicate
// and dropped appends, hit count saturation) is followed by random episodes
// of clear, fill and probe sets; every response is checked by field against
// a typed row answer or a behavioural model of the set and its running values
// ----------------------------------------------------------------------------

module index_set_intersection_unit_tb;

   import isi_pkg::*;

   // the one command code the package leaves unnamed; taken and discarded
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   localparam int RANDOM_ITEMS = 860;
   localparam int RESET_CYCLES = 12;
   // the response path through both buffers, with margin
   localparam int DRAIN_CYCLES = 16;
   // far beyond the slowest legal run: ~1400 requests, each with a sender
   // gap and a full receiver stall pattern in front of it
   localparam int RUN_LIMIT_NS = 5_000_000;

   // one row of the directed table; value advances by stride per repeat
   typedef struct packed {
      logic [1:0]         cmd;
      logic [VALUE_W-1:0] value;
      logic               last;
      int                 reps;
      int                 stride;
      bit                 typed;
      rsp_type            answer;
   } stim_row_type;

   localparam int NUM_ROWS = 22;
   localparam stim_row_type DIRECTED_ROWS [NUM_ROWS] = '{
      // empty set straight after reset: never a member, subset flag drops
      '{CMD_PROBE,  32'h0000_0000, 1'b0, 1, 0, 1'b1,
        '{32'h0000_0000, 1'b0, 1'b0, 6'd0, 1'b0, 1'b0}},
      '{CMD_PROBE,  32'hFFFF_FFFF, 1'b1, 1, 0, 1'b1,
        '{32'hFFFF_FFFF, 1'b0, 1'b0, 6'd0, 1'b0, 1'b1}},
      // unused code must leave everything alone
      '{CMD_UNUSED, 32'hFFFF_FFFF, 1'b1, 1, 0, 1'b0, '0},
      '{CMD_PROBE,  32'h0000_0000, 1'b1, 1, 0, 1'b1,
        '{32'h0000_0000, 1'b0, 1'b0, 6'd0, 1'b0, 1'b1}},
      // extremes plus a duplicate entry
      '{CMD_APPEND, 32'h0000_0000, 1'b0, 1, 0, 1'b0, '0},
      '{CMD_APPEND, 32'hFFFF_FFFF, 1'b0, 1, 0, 1'b0, '0},
      '{CMD_APPEND, 32'h0000_0000, 1'b0, 1, 0, 1'b0, '0},
      '{CMD_PROBE,  32'h0000_0000, 1'b0, 1, 0, 1'b0, '0},
      '{CMD_PROBE,  32'hFFFF_FFFF, 1'b0, 1, 0, 1'b0, '0},
      // near misses, one bit away from a stored index
      '{CMD_PROBE,  32'h7FFF_FFFF, 1'b0, 1, 0, 1'b0, '0},
      '{CMD_PROBE,  32'hFFFF_FFFE, 1'b1, 1, 0, 1'b0, '0},
      '{CMD_PROBE,  32'h0000_0001, 1'b1, 1, 0, 1'b0, '0},
      // clear ignores its last bit and empties the set
      '{CMD_CLEAR,  32'h0000_0000, 1'b1, 1, 0, 1'b0, '0},
      '{CMD_PROBE,  32'hFFFF_FFFF, 1'b1, 1, 0, 1'b1,
        '{32'hFFFF_FFFF, 1'b0, 1'b0, 6'd0, 1'b0, 1'b1}},
      // fill past capacity: the last two appends are dropped
      '{CMD_APPEND, 32'd100, 1'b0, CAPACITY + 2, 1, 1'b0, '0},
      '{CMD_PROBE,  32'd100 + CAPACITY - 1, 1'b0, 1, 0, 1'b0, '0},
      '{CMD_PROBE,  32'd100 + CAPACITY, 1'b0, 1, 0, 1'b0, '0},
      // long probe set drives the hit count into saturation
      '{CMD_PROBE,  32'd100, 1'b0, 70, 0, 1'b0, '0},
      '{CMD_PROBE,  32'd101, 1'b1, 1, 0, 1'b0, '0},
      '{CMD_PROBE,  32'd101, 1'b1, 1, 0, 1'b0, '0},
      // clear drops the overflow flag
      '{CMD_CLEAR,  32'h0000_0000, 1'b0, 1, 0, 1'b0, '0},
      '{CMD_PROBE,  32'd101, 1'b1, 1, 0, 1'b1,
        '{32'd101, 1'b0, 1'b0, 6'd0, 1'b0, 1'b1}}
   };

   logic               clock = 1'b0;
   logic               reset;
   logic               req_push;
   logic               req_full;
   logic [1:0]         req_cmd;
   logic [VALUE_W-1:0] req_value;
   logic               req_last;
   logic               rsp_empty;
   logic               rsp_pop;
   logic [VALUE_W-1:0] rsp_probe_index;
   logic               rsp_is_member;
   logic               rsp_all_members;
   logic [HITS_W-1:0]  rsp_common_count;
   logic               rsp_overflowed;
   logic               rsp_final_res;

   index_set_intersection_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_cmd          (req_cmd),
      .req_value        (req_value),
      .req_last         (req_last),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_probe_index  (rsp_probe_index),
      .rsp_is_member    (rsp_is_member),
      .rsp_all_members  (rsp_all_members),
      .rsp_common_count (rsp_common_count),
      .rsp_overflowed   (rsp_overflowed),
      .rsp_final_res    (rsp_final_res)
   );

   // 8 ns period
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // behavioural copy of the reference set and the running probe values
   // ---------------------------------------------------------------------
   logic [KEY_W-1:0]  stored_index [CAPACITY];
   int                stored_count = 0;
   bit                append_lost  = 1'b0;
   bit                still_subset = 1'b1;
   logic [HITS_W-1:0] hit_total    = '0;

   rsp_type awaited_answers [$];
   int      error_count = 0;
   int      sent_items  = 0;
   int      burst_left  = 0;

   // applies one accepted request to the model; returns 1 when it yields
   // a response, which is left in answer
   function automatic bit answer_request(input logic [1:0] cmd,
                                         input logic [VALUE_W-1:0] value,
                                         input logic last,
                                         output rsp_type answer);
      logic [KEY_W-1:0] key;
      bit               hit;
      key    = value[KEY_W-1:0];
      hit    = 1'b0;
      answer = '0;
      case (cmd)
         CMD_CLEAR: begin
            stored_count = 0;
            append_lost  = 1'b0;
            still_subset = 1'b1;
            hit_total    = '0;
            return 1'b0;
         end
         CMD_APPEND: begin
            if (stored_count < CAPACITY) begin
               stored_index[stored_count] = key;
               stored_count++;
            end else begin
               append_lost = 1'b1;
            end
            return 1'b0;
         end
         CMD_PROBE: begin
            for (int i = 0; i < stored_count; i++)
               if (stored_index[i] == key)
                  hit = 1'b1;
            if (hit) begin
               if (hit_total != HITS_MAX)
                  hit_total++;
            end else begin
               still_subset = 1'b0;
            end
            answer.probe_index  = value;
            answer.is_member    = hit;
            answer.all_members  = still_subset;
            answer.common_count = hit_total;
            answer.overflowed   = append_lost;
            answer.final_res    = last;
            // running values restart once the set's final response is out
            if (last) begin
               still_subset = 1'b1;
               hit_total    = '0;
            end
            return 1'b1;
         end
         default: return 1'b0;
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // request side: bursts of random length separated by random gaps;
   // called and returning on a falling edge
   // ---------------------------------------------------------------------
   task automatic send_request(input logic [1:0] cmd, input logic [VALUE_W-1:0] value,
                               input logic last, input bit typed,
                               input rsp_type typed_answer);
      rsp_type predicted;
      bit      gives_answer;
      if (burst_left == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 7)) @(negedge clock);
         // mostly short bursts, now and then a long unbroken stretch
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 90)
                                                  : $urandom_range(1, 10);
      end
      burst_left--;
      req_push  <= 1'b1;
      req_cmd   <= cmd;
      req_value <= value;
      req_last  <= last;
      @(posedge clock);
      while (req_full)
         @(posedge clock);
      gives_answer = answer_request(cmd, value, last, predicted);
      if (gives_answer)
         awaited_answers.push_back(typed ? typed_answer : predicted);
      if (cmd != CMD_UNUSED)
         sent_items++;
      @(negedge clock);
   endtask

   // sprinkles the unused code in as noise
   task automatic maybe_send_unused();
      if ($urandom_range(0, 19) == 0)
         send_request(CMD_UNUSED, $urandom, 1'($urandom_range(0, 1)), 1'b0, '0);
   endtask

   // probe index: mostly a stored one, else a one-bit near miss or random
   function automatic logic [VALUE_W-1:0] pick_probe_value(input bit want_member);
      int                 mode;
      logic [VALUE_W-1:0] chosen;
      mode = want_member ? 0 : $urandom_range(0, 9);
      if (stored_count == 0 || mode >= 8)
         return $urandom;
      chosen = stored_index[$urandom_range(0, stored_count - 1)];
      if (mode >= 6)
         chosen[$urandom_range(0, VALUE_W - 1)] ^= 1'b1;
      return chosen;
   endfunction

   // ---------------------------------------------------------------------
   // response side: the pop pattern is redrawn when its run is used up, from
   // always ready through random to mostly stalled
   // ---------------------------------------------------------------------
   logic [7:0] pop_pattern = 8'hFF;
   int         pattern_left = 0;

   initial begin
      rsp_pop = 1'b0;
      forever begin
         @(negedge clock);
         if (pattern_left == 0) begin
            case ($urandom_range(0, 3))
               0: pop_pattern = 8'hFF;
               1: pop_pattern = 8'($urandom);
               2: pop_pattern = 8'h11;
               default: pop_pattern = 8'h80;
            endcase
            pattern_left = 48;
         end
         pattern_left--;
         rsp_pop <= pop_pattern[pattern_left % 8];
      end
   end

   task automatic compare_field(input string name, input logic [VALUE_W-1:0] want,
                                input logic [VALUE_W-1:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         error_count++;
      end
   endtask

   // a response leaves on a rising edge with pop high and empty low
   always @(posedge clock) begin : response_check
      rsp_type oldest;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (awaited_answers.size() == 0) begin
            $error("response with none awaited: probe_index 0x%0h", rsp_probe_index);
            error_count++;
         end else begin
            oldest = awaited_answers.pop_front();
            compare_field("probe_index",  oldest.probe_index,  rsp_probe_index);
            compare_field("is_member",    VALUE_W'(oldest.is_member),
                          VALUE_W'(rsp_is_member));
            compare_field("all_members",  VALUE_W'(oldest.all_members),
                          VALUE_W'(rsp_all_members));
            compare_field("common_count", VALUE_W'(oldest.common_count),
                          VALUE_W'(rsp_common_count));
            compare_field("overflowed",   VALUE_W'(oldest.overflowed),
                          VALUE_W'(rsp_overflowed));
            compare_field("final_res",    VALUE_W'(oldest.final_res),
                          VALUE_W'(rsp_final_res));
         end
      end
   end

   // ---------------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------------
   initial begin : stimulus
      bit   long_set;
      int   fill;
      int   set_len;
      int   random_target;
      logic probe_last;
      reset     = 1'b1;
      req_push  = 1'b0;
      req_cmd   = CMD_CLEAR;
      req_value = '0;
      req_last  = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed table
      foreach (DIRECTED_ROWS[r])
         for (int k = 0; k < DIRECTED_ROWS[r].reps; k++)
            send_request(DIRECTED_ROWS[r].cmd,
                         DIRECTED_ROWS[r].value + VALUE_W'(k * DIRECTED_ROWS[r].stride),
                         DIRECTED_ROWS[r].last, DIRECTED_ROWS[r].typed,
                         DIRECTED_ROWS[r].answer);

      // random episodes: usually clear, fill, then one probe set
      random_target = sent_items + RANDOM_ITEMS;
      while (sent_items < random_target) begin
         // an occasional long all-member set to reach count saturation
         long_set = ($urandom_range(0, 11) == 0);
         if (long_set || $urandom_range(0, 3) != 0)
            send_request(CMD_CLEAR, $urandom, 1'($urandom_range(0, 1)), 1'b0, '0);
         if (long_set)
            fill = $urandom_range(1, 4);
         else if ($urandom_range(0, 3) == 0)
            fill = $urandom_range(CAPACITY - 4, CAPACITY + 3);
         else
            fill = $urandom_range(0, 8);
         repeat (fill) begin
            maybe_send_unused();
            // some appends repeat an index already held
            send_request(CMD_APPEND,
                         ($urandom_range(0, 5) == 0) ? pick_probe_value(1'b1) : $urandom,
                         1'($urandom_range(0, 1)), 1'b0, '0);
         end
         set_len = long_set ? $urandom_range(66, 72) : $urandom_range(1, 8);
         for (int p = 0; p < set_len; p++) begin
            maybe_send_unused();
            // a set now and then runs on without its final mark
            probe_last = (p == set_len - 1) && ($urandom_range(0, 7) != 0);
            send_request(CMD_PROBE, pick_probe_value(long_set), probe_last, 1'b0, '0);
         end
      end
      req_push <= 1'b0;

      while (awaited_answers.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   // watchdog
   initial begin
      #(RUN_LIMIT_NS);
      $display("FAILED: results differ");
      $finish;
   end

endmodule
